// ===== sv/gtg_pkg.sv =====
// Package for the go-to-goal steering controller: payload types, register codes and constants.
`default_nettype none

package gtg_pkg;

   // CORDIC iteration count, usable from 8 to 24.
   localparam int CORDIC_ITERATIONS = 16;
   localparam int ITER_W = $clog2(CORDIC_ITERATIONS);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

   // The square root takes one result bit per step.
   localparam int SQRT_STEPS = 32;
   localparam int SQRT_W = $clog2(SQRT_STEPS);
   localparam logic [SQRT_W-1:0] SQRT_LAST = SQRT_W'(SQRT_STEPS - 1);
   localparam logic [63:0] SQRT_B_INIT = 64'h4000_0000_0000_0000;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_ANGULAR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_LINEAR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARRIVE_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADING_THRESHOLD = 2'd3;

   // Register reset values.
   localparam logic [15:0] GAIN_ANGULAR_RESET = 16'd45875;
   localparam logic [15:0] GAIN_LINEAR_RESET = 16'd29491;
   localparam logic [15:0] ARRIVE_THRESHOLD_RESET = 16'd3277;
   localparam logic [14:0] HEADING_THRESHOLD_RESET = 15'd12868;

   // Angle constants: pi in units of 2^-24 rad and pi, 2pi in Q3.13.
   localparam logic signed [27:0] PI_A24 = 28'sd52707179;
   localparam logic signed [17:0] PI_Q13 = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

   // One in Q2.28 for the heading x term.
   localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

   // Largest linear command.
   localparam logic [30:0] LINEAR_MAX = 31'h7FFF_FFFF;

   // Arctangent of 2^-i in units of 2^-24 rad.
   localparam logic [23:0] ATAN_TAB [0:23] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
      24'd1047214, 24'd524117, 24'd262123, 24'd131069,
      24'd65536, 24'd32768, 24'd16384, 24'd8192,
      24'd4096, 24'd2048, 24'd1024, 24'd512,
      24'd256, 24'd128, 24'd64, 24'd32,
      24'd16, 24'd8, 24'd4, 24'd2
   };

   function automatic logic [23:0] atan_a24(input logic [ITER_W-1:0] idx);
      return ATAN_TAB[idx];
   endfunction

   // Input item.
   typedef struct packed {
      logic               mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] new_goal_x;
      logic signed [31:0] new_goal_y;
   } gtg_req_type;

   // Result item.
   typedef struct packed {
      logic signed [15:0] angular_cmd;
      logic [30:0]        linear_cmd;
      logic               heading_aligned;
   } gtg_rsp_type;

endpackage

`default_nettype wire

// ===== sv/go_to_goal_heading_distance_control_top.sv =====
// Go-to-goal steering controller built around one shared multiplier and one CORDIC unit.
//
// Usage: an item on the req_ channel with mode 1 stores a new goal point and gives no
// result. An item with mode 0 is an odometry sample. When the robot is within the
// arrival distance, the sample gives no result; otherwise one result leaves on the
// rsp_ channel with the angular command, the linear command and the aligned flag.
// Both channels move a transfer at a clock edge where valid is high and stall is low.
// Write registers through csr_we, csr_index and csr_wdata only while the block is idle;
// the block itself does not enforce this. A goal item leaves the block idle. A sample
// inside the arrival distance passes through the magnitude, square and arrival steps.
// Other samples run the CORDIC iteration loop twice, for heading and then bearing, and the
// angular product; when the heading is aligned the bit-serial distance square root (one
// bit per cycle) and linear product follow, then the result goes to the output register.
// req_stall is high while one sample is being worked on; one finished result can wait
// in the output register while the next item is taken.
// Reset (synchronous, active high) restores the register defaults, clears the goal
// and the held linear command and drops rsp_valid. While the receiver stalls, the
// result is held and a following result waits in its last step.
`default_nettype none

module go_to_goal_heading_distance_control_top
   import gtg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire gtg_req_type            req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output gtg_rsp_type                 rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Sequencer states.
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_ABS    = 5'd1;
   localparam logic [4:0] S_SQX    = 5'd2;
   localparam logic [4:0] S_SQY    = 5'd3;
   localparam logic [4:0] S_SQT    = 5'd4;
   localparam logic [4:0] S_ARRIVE = 5'd5;
   localparam logic [4:0] S_HQZ    = 5'd6;
   localparam logic [4:0] S_HLOAD  = 5'd7;
   localparam logic [4:0] S_CINIT  = 5'd8;
   localparam logic [4:0] S_CITER  = 5'd9;
   localparam logic [4:0] S_CDONE  = 5'd10;
   localparam logic [4:0] S_DIFF   = 5'd11;
   localparam logic [4:0] S_ANG    = 5'd12;
   localparam logic [4:0] S_ANGW   = 5'd13;
   localparam logic [4:0] S_SQRT   = 5'd14;
   localparam logic [4:0] S_LIN    = 5'd15;
   localparam logic [4:0] S_LINW   = 5'd16;
   localparam logic [4:0] S_FIN    = 5'd17;

   // Control registers.
   logic [4:0]          state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                pass_ff, pass_in;
   logic [ITER_W-1:0]   it_ff, it_in;
   logic [SQRT_W-1:0]   sq_cnt_ff, sq_cnt_in;
   logic [15:0]         gain_angular_ff, gain_angular_in;
   logic [15:0]         gain_linear_ff, gain_linear_in;
   logic [15:0]         arrive_thr_ff, arrive_thr_in;
   logic [14:0]         heading_thr_ff, heading_thr_in;
   logic signed [31:0]  goal_x_ff, goal_x_in;
   logic signed [31:0]  goal_y_ff, goal_y_in;
   logic [30:0]         held_linear_ff, held_linear_in;

   // Datapath registers.
   logic signed [32:0]  dx_ff, dx_in;
   logic signed [32:0]  dy_ff, dy_in;
   logic signed [15:0]  qz_ff, qz_in;
   logic signed [15:0]  qw_ff, qw_in;
   logic [30:0]         axh_ff, axh_in;
   logic [30:0]         ayh_ff, ayh_in;
   logic                sc_ff, sc_in;
   logic                near_ff, near_in;
   logic [62:0]         sumsq_ff, sumsq_in;
   logic signed [65:0]  prod_ff, prod_in;
   logic signed [35:0]  cx_ff, cx_in;
   logic signed [35:0]  cy_ff, cy_in;
   logic signed [27:0]  cz_ff, cz_in;
   logic                zero_ff, zero_in;
   logic signed [16:0]  theta_ff, theta_in;
   logic signed [16:0]  phi_ff, phi_in;
   logic signed [17:0]  err_ff, err_in;
   logic                aligned_ff, aligned_in;
   logic [15:0]         ang_ff, ang_in;
   logic [63:0]         sq_n_ff, sq_n_in;
   logic [63:0]         sq_r_ff, sq_r_in;
   logic [63:0]         sq_b_ff, sq_b_in;
   gtg_rsp_type         rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic                req_accept;
   logic signed [32:0]  mul_a, mul_b;
   logic [32:0]         abs_x, abs_y;
   logic                sc_flag;
   logic signed [35:0]  xs, ys;
   logic signed [27:0]  atan_ext;
   logic signed [27:0]  z_round;
   logic signed [16:0]  angle;
   logic signed [17:0]  diff;
   logic [17:0]         diff_abs;
   logic [34:0]         ang_round;
   logic [63:0]         sq_sum;
   logic                sq_ge;
   logic [49:0]         lin_scaled, lin_round;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Shared multiplier: operands are picked by the sequencer, the product is registered.
   always_comb begin
      unique case (state_ff)
         S_SQX: begin
            mul_a = {2'b00, axh_ff};
            mul_b = {2'b00, axh_ff};
         end
         S_SQY: begin
            mul_a = {2'b00, ayh_ff};
            mul_b = {2'b00, ayh_ff};
         end
         S_SQT: begin
            mul_a = {17'b0, arrive_thr_ff};
            mul_b = {17'b0, arrive_thr_ff};
         end
         S_ARRIVE: begin
            mul_a = {{17{qw_ff[15]}}, qw_ff};
            mul_b = {{17{qz_ff[15]}}, qz_ff};
         end
         S_HQZ: begin
            mul_a = {{17{qz_ff[15]}}, qz_ff};
            mul_b = {{17{qz_ff[15]}}, qz_ff};
         end
         S_ANG: begin
            mul_a = {17'b0, gain_angular_ff};
            mul_b = {{15{err_ff[17]}}, err_ff};
         end
         S_LIN: begin
            mul_a = {17'b0, gain_linear_ff};
            mul_b = {1'b0, sq_r_ff[31:0]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Offset magnitudes, with a halving step when either reaches 2^31.
   assign abs_x   = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign abs_y   = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign sc_flag = abs_x[31] | abs_y[31];

   // CORDIC shift-add unit and angle rounding to Q3.13.
   assign xs       = cx_ff >>> it_ff;
   assign ys       = cy_ff >>> it_ff;
   assign atan_ext = {4'b0000, atan_a24(it_ff)};
   assign z_round  = cz_ff + 28'sd1024;
   assign angle    = zero_ff ? '0 : z_round[27:11];

   // Heading difference, before wrapping.
   assign diff     = {theta_ff[16], theta_ff} - {phi_ff[16], phi_ff};
   assign diff_abs = diff[17] ? 18'(-diff) : 18'(diff);

   // Rounded, negated angular product; only the low 16 bits of the shifted value are kept.
   assign ang_round = 35'd32768 - prod_ff[34:0];

   // Bit-serial square root step.
   assign sq_sum = sq_r_ff + sq_b_ff;
   assign sq_ge  = (sq_n_ff >= sq_sum);

   // Linear product, undoing the halving, then rounding.
   assign lin_scaled = sc_ff ? {1'b0, prod_ff[47:0], 1'b0} : {2'b00, prod_ff[47:0]};
   assign lin_round  = lin_scaled + 50'd32768;

   // Sequencer and next-state logic.
   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      pass_in         = pass_ff;
      it_in           = it_ff;
      sq_cnt_in       = sq_cnt_ff;
      gain_angular_in = gain_angular_ff;
      gain_linear_in  = gain_linear_ff;
      arrive_thr_in   = arrive_thr_ff;
      heading_thr_in  = heading_thr_ff;
      goal_x_in       = goal_x_ff;
      goal_y_in       = goal_y_ff;
      held_linear_in  = held_linear_ff;
      dx_in           = dx_ff;
      dy_in           = dy_ff;
      qz_in           = qz_ff;
      qw_in           = qw_ff;
      axh_in          = axh_ff;
      ayh_in          = ayh_ff;
      sc_in           = sc_ff;
      near_in         = near_ff;
      sumsq_in        = sumsq_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      cz_in           = cz_ff;
      zero_in         = zero_ff;
      theta_in        = theta_ff;
      phi_in          = phi_ff;
      err_in          = err_ff;
      aligned_in      = aligned_ff;
      ang_in          = ang_ff;
      sq_n_in         = sq_n_ff;
      sq_r_in         = sq_r_ff;
      sq_b_in         = sq_b_ff;
      rsp_data_in     = rsp_data_ff;

      // Register writes.
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_ANGULAR:      gain_angular_in = csr_wdata;
            CSR_GAIN_LINEAR:       gain_linear_in  = csr_wdata;
            CSR_ARRIVE_THRESHOLD:  arrive_thr_in   = csr_wdata;
            CSR_HEADING_THRESHOLD: heading_thr_in  = csr_wdata[14:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_data.mode) begin
                  goal_x_in = req_data.new_goal_x;
                  goal_y_in = req_data.new_goal_y;
               end else begin
                  dx_in    = {goal_x_ff[31], goal_x_ff} - {req_data.pos_x[31], req_data.pos_x};
                  dy_in    = {goal_y_ff[31], goal_y_ff} - {req_data.pos_y[31], req_data.pos_y};
                  qz_in    = req_data.quat_z;
                  qw_in    = req_data.quat_w;
                  state_in = S_ABS;
               end
            end
         end
         S_ABS: begin
            sc_in    = sc_flag;
            axh_in   = sc_flag ? abs_x[31:1] : abs_x[30:0];
            ayh_in   = sc_flag ? abs_y[31:1] : abs_y[30:0];
            near_in  = (abs_x[31:16] == '0) && (abs_y[31:16] == '0);
            state_in = S_SQX;
         end
         S_SQX: begin
            state_in = S_SQY;
         end
         S_SQY: begin
            sumsq_in = {1'b0, prod_ff[61:0]};
            state_in = S_SQT;
         end
         S_SQT: begin
            sumsq_in = sumsq_ff + {1'b0, prod_ff[61:0]};
            state_in = S_ARRIVE;
         end
         S_ARRIVE: begin
            // Inside the arrival circle the sample is dropped.
            if (near_ff && (sumsq_ff <= {31'b0, prod_ff[31:0]})) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_HQZ;
            end
         end
         S_HQZ: begin
            cy_in    = {prod_ff[34:0], 1'b0};
            state_in = S_HLOAD;
         end
         S_HLOAD: begin
            cx_in    = ONE_Q28 - {prod_ff[34:0], 1'b0};
            pass_in  = 1'b0;
            state_in = S_CINIT;
         end
         S_CINIT: begin
            // Zero test and rotation by pi into the right half plane.
            zero_in = (cx_ff == '0) && (cy_ff == '0);
            it_in   = '0;
            if (cx_ff[35]) begin
               cx_in = -cx_ff;
               cy_in = -cy_ff;
               cz_in = cy_ff[35] ? -PI_A24 : PI_A24;
            end else begin
               cz_in = '0;
            end
            state_in = S_CITER;
         end
         S_CITER: begin
            if (!cy_ff[35] && (cy_ff != '0)) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_ext;
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_ext;
            end
            it_in = it_ff + ITER_W'(1);
            if (it_ff == ITER_LAST) begin
               state_in = S_CDONE;
            end
         end
         S_CDONE: begin
            if (!pass_ff) begin
               // Heading done; start the bearing to the goal.
               theta_in = angle;
               cx_in    = {{3{dx_ff[32]}}, dx_ff};
               cy_in    = {{3{dy_ff[32]}}, dy_ff};
               pass_in  = 1'b1;
               state_in = S_CINIT;
            end else begin
               phi_in   = angle;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            priority if (diff > PI_Q13) begin
               err_in = diff - TWO_PI_Q13;
            end else if (diff < -PI_Q13) begin
               err_in = diff + TWO_PI_Q13;
            end else begin
               err_in = diff;
            end
            aligned_in = (diff_abs < {3'b000, heading_thr_ff});
            state_in   = S_ANG;
         end
         S_ANG: begin
            state_in = S_ANGW;
         end
         S_ANGW: begin
            ang_in = ang_round[31:16];
            if (aligned_ff) begin
               sq_n_in   = {1'b0, sumsq_ff};
               sq_r_in   = '0;
               sq_b_in   = SQRT_B_INIT;
               sq_cnt_in = '0;
               state_in  = S_SQRT;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SQRT: begin
            if (sq_ge) begin
               sq_n_in = sq_n_ff - sq_sum;
               sq_r_in = (sq_r_ff >> 1) + sq_b_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_b_in   = sq_b_ff >> 2;
            sq_cnt_in = sq_cnt_ff + SQRT_W'(1);
            if (sq_cnt_ff == SQRT_LAST) begin
               state_in = S_LIN;
            end
         end
         S_LIN: begin
            state_in = S_LINW;
         end
         S_LINW: begin
            held_linear_in = (lin_round[49:47] != '0) ? LINEAR_MAX : lin_round[46:16];
            state_in       = S_FIN;
         end
         S_FIN: begin
            // Load the output register once it is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.angular_cmd     = ang_ff;
               rsp_data_in.linear_cmd      = held_linear_ff;
               rsp_data_in.heading_aligned = aligned_ff;
               rsp_valid_in                = 1'b1;
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         pass_ff         <= 1'b0;
         it_ff           <= '0;
         sq_cnt_ff       <= '0;
         gain_angular_ff <= GAIN_ANGULAR_RESET;
         gain_linear_ff  <= GAIN_LINEAR_RESET;
         arrive_thr_ff   <= ARRIVE_THRESHOLD_RESET;
         heading_thr_ff  <= HEADING_THRESHOLD_RESET;
         goal_x_ff       <= '0;
         goal_y_ff       <= '0;
         held_linear_ff  <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         pass_ff         <= pass_in;
         it_ff           <= it_in;
         sq_cnt_ff       <= sq_cnt_in;
         gain_angular_ff <= gain_angular_in;
         gain_linear_ff  <= gain_linear_in;
         arrive_thr_ff   <= arrive_thr_in;
         heading_thr_ff  <= heading_thr_in;
         goal_x_ff       <= goal_x_in;
         goal_y_ff       <= goal_y_in;
         held_linear_ff  <= held_linear_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      qz_ff       <= qz_in;
      qw_ff       <= qw_in;
      axh_ff      <= axh_in;
      ayh_ff      <= ayh_in;
      sc_ff       <= sc_in;
      near_ff     <= near_in;
      sumsq_ff    <= sumsq_in;
      prod_ff     <= prod_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      zero_ff     <= zero_in;
      theta_ff    <= theta_in;
      phi_ff      <= phi_in;
      err_ff      <= err_in;
      aligned_ff  <= aligned_in;
      ang_ff      <= ang_in;
      sq_n_ff     <= sq_n_in;
      sq_r_ff     <= sq_r_in;
      sq_b_ff     <= sq_b_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== sv/gtg_checker.sv =====
// Port-level checker for the go-to-goal steering controller, with its bind statement.
`default_nettype none

module gtg_checker
   import gtg_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire gtg_req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire gtg_rsp_type rsp_data
);

   // A new result only appears out of a busy period.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

   // A goal transfer never makes the block busy.
   a_goal_no_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.mode) |=> !req_stall)
      else $error("goal transfer stalled the input");

   // An odometry transfer makes the block busy and stalls the input.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_data.mode) |=> req_stall)
      else $error("input taken again right after an odometry transfer");

   // A stalled result stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

endmodule

bind go_to_goal_heading_distance_control_top gtg_checker u_gtg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
